// ===== src/bms_pkg.sv =====
// bms_pkg: shared types and constants for the buzzer melody sequencer
// no dependencies; imported by buzzer_melody_sequencer_core
package bms_pkg;

  // note store geometry
  localparam int NOTE_SLOTS     = 16;
  localparam int SLOT_W         = $clog2(NOTE_SLOTS);
  localparam int COUNT_W        = 5;
  localparam int TICKS_PER_BEAT = 700;
  localparam int HALF_W         = 16;
  localparam int BEATS_W        = 8;
  localparam int BEAT_TICKS_W   = 18;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOTE_COUNT  = 1'b0,
    CFG_PLAY_ENABLE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [3:0]         note_slot;
    logic [HALF_W-1:0]  half_period;
    logic [BEATS_W-1:0] beat_units;
  } in_item_t;

  typedef struct packed {
    logic       pin_level;
    logic [3:0] current_note;
    logic       note_advanced;
  } out_item_t;

endpackage

// ===== src/buzzer_melody_sequencer_core.sv =====
// buzzer_melody_sequencer_core: square-wave melody player, note store and tone counters
// depends on bms_pkg
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready  in_data   (in_item_t)
//   out       output     out_valid/ out_ready out_data  (out_item_t)
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// one transaction per cycle while the result is not stalled; a result appears in the cycle after its item is taken
// the note store is a flip-flop array read at one address (next note) per tick,
// with the current note's half-period shadowed in its own register
// the result register holds one result; in_ready drops while it is held with out_ready low
// reset clears counters, pin and position, sets note count to 1 and disables play; the note store is left unset
module buzzer_melody_sequencer_core
  import bms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // note store
  logic [HALF_W-1:0]       period_store [NOTE_SLOTS];
  logic [BEAT_TICKS_W-1:0] beat_store   [NOTE_SLOTS];

  // play state
  logic [SLOT_W-1:0]       note_position;
  logic [HALF_W-1:0]       toggle_countdown;
  logic [BEAT_TICKS_W-1:0] beat_countdown;
  logic                    pin_state;
  logic [HALF_W-1:0]       cur_period;
  logic [COUNT_W-1:0]      note_count;
  logic                    play_enable;

  logic [SLOT_W-1:0]       note_position_next;
  logic [HALF_W-1:0]       toggle_countdown_next;
  logic [BEAT_TICKS_W-1:0] beat_countdown_next;
  logic                    pin_state_next;
  logic [HALF_W-1:0]       cur_period_next;
  logic                    advanced;

  logic                    accept;
  logic                    is_write;
  logic [COUNT_W-1:0]      eff_count;
  logic [COUNT_W-1:0]      pos_inc;
  logic [SLOT_W-1:0]       next_slot;
  logic [BEAT_TICKS_W-1:0] write_ticks;
  logic [HALF_W-1:0]       toggle_tmp;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_write = (in_data.opcode == OP_WRITE);

  // beat length in ticks, worked out when the note is written
  assign write_ticks = BEAT_TICKS_W'(in_data.beat_units) * BEAT_TICKS_W'(TICKS_PER_BEAT);

  // effective note count and the index that follows the current one
  always_comb begin
    eff_count = note_count;
    if (note_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (note_count > COUNT_W'(NOTE_SLOTS)) begin
      eff_count = COUNT_W'(NOTE_SLOTS);
    end
    pos_inc = COUNT_W'(note_position) + COUNT_W'(1);
    if (pos_inc >= eff_count) begin
      next_slot = '0;
    end else begin
      next_slot = pos_inc[SLOT_W-1:0];
    end
  end

  // tick update and current-note shadow
  always_comb begin
    note_position_next    = note_position;
    toggle_countdown_next = toggle_countdown;
    beat_countdown_next   = beat_countdown;
    pin_state_next        = pin_state;
    cur_period_next       = cur_period;
    advanced              = 1'b0;
    toggle_tmp            = toggle_countdown;
    if (is_write) begin
      if (in_data.note_slot == note_position) begin
        cur_period_next = in_data.half_period;
      end
    end else if (play_enable) begin
      if (toggle_countdown == '0) begin
        toggle_tmp     = cur_period;
        pin_state_next = !pin_state;
      end
      beat_countdown_next = beat_countdown - BEAT_TICKS_W'(1);
      if (beat_countdown == '0) begin
        note_position_next  = next_slot;
        toggle_tmp          = period_store[next_slot];
        cur_period_next     = period_store[next_slot];
        beat_countdown_next = beat_store[next_slot] - BEAT_TICKS_W'(1);
        advanced            = 1'b1;
      end
      toggle_countdown_next = toggle_tmp - HALF_W'(1);
    end
  end

  // note store writes
  always_ff @(posedge clk) begin
    if (accept && is_write) begin
      period_store[in_data.note_slot] <= in_data.half_period;
      beat_store[in_data.note_slot]   <= write_ticks;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      note_count  <= COUNT_W'(1);
      play_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOTE_COUNT:  note_count  <= cfg_data;
        CFG_PLAY_ENABLE: play_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // play state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      note_position    <= '0;
      toggle_countdown <= '0;
      beat_countdown   <= '0;
      pin_state        <= 1'b0;
    end else if (accept) begin
      note_position    <= note_position_next;
      toggle_countdown <= toggle_countdown_next;
      beat_countdown   <= beat_countdown_next;
      pin_state        <= pin_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_period <= cur_period_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.pin_level     <= pin_state_next;
      out_data.current_note  <= note_position_next;
      out_data.note_advanced <= advanced;
    end
  end

`ifndef SYNTHESIS
  // a held result blocks new transactions
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // result mirrors the play state it was built from
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pin_level == pin_state) &&
                  (out_data.current_note == note_position))
    else $error("result out of step with play state");

  // an enabled tick with an expired beat moves to the next note
  a_beat_expiry_advances: assert property (@(posedge clk) disable iff (rst)
    accept && !is_write && play_enable && (beat_countdown == '0)
    |=> out_valid && out_data.note_advanced)
    else $error("beat expiry did not advance note");

  // a note write never advances the melody
  a_write_no_advance: assert property (@(posedge clk) disable iff (rst)
    accept && is_write |=> out_valid && !out_data.note_advanced &&
                           $stable(note_position) && $stable(beat_countdown))
    else $error("note write disturbed playback");

  // a disabled tick leaves the counters alone
  a_disabled_tick_idle: assert property (@(posedge clk) disable iff (rst)
    accept && !is_write && !play_enable |=> $stable(toggle_countdown) &&
                                           $stable(pin_state))
    else $error("disabled tick changed tone state");
`endif

endmodule
